FILE: src/cso_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and sprite tables for the cursor sprite overlay.
// No dependencies; every other file imports this package.

package cso_pkg;

    localparam int CSO_COORD_BITS = 12;   // default pixel coordinate width
    localparam int CFG_W          = 13;   // cursor position and screen size width
    localparam int COLOR_W        = 32;
    localparam int CFG_DATA_W     = 32;   // widest register
    localparam int CFG_IDX_W      = 3;
    localparam int SPRITE_ROWS    = 16;
    localparam int SPRITE_COLS    = 8;
    localparam int ROW_BITS       = $clog2(SPRITE_ROWS);
    localparam int COL_BITS       = $clog2(SPRITE_COLS);

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CURSOR_X      = 3'd0,
        REG_CURSOR_Y      = 3'd1,
        REG_SCREEN_WIDTH  = 3'd2,
        REG_SCREEN_HEIGHT = 3'd3,
        REG_BORDER_COLOR  = 3'd4,
        REG_FILL_COLOR    = 3'd5
    } cfg_reg_t;

    localparam logic [CFG_W-1:0]   RST_CURSOR_X      = 13'd0;
    localparam logic [CFG_W-1:0]   RST_CURSOR_Y      = 13'd0;
    localparam logic [CFG_W-1:0]   RST_SCREEN_WIDTH  = 13'd1024;
    localparam logic [CFG_W-1:0]   RST_SCREEN_HEIGHT = 13'd768;
    localparam logic [COLOR_W-1:0] RST_BORDER_COLOR  = 32'h0000_0000;
    localparam logic [COLOR_W-1:0] RST_FILL_COLOR    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [CFG_W-1:0] cursor_x;
        logic signed [CFG_W-1:0] cursor_y;
        logic [CFG_W-1:0]        screen_width;
        logic [CFG_W-1:0]        screen_height;
        logic [COLOR_W-1:0]      border_color;
        logic [COLOR_W-1:0]      fill_color;
    } cso_cfg_t;

    // Arrow bitmap, one byte per row, MSB is column 0
    function automatic logic [SPRITE_COLS-1:0] arrow_row(input logic [ROW_BITS-1:0] row);
        logic [SPRITE_COLS-1:0] bits;
        case (row)
            4'd0:    bits = 8'h80;
            4'd1:    bits = 8'hC0;
            4'd2:    bits = 8'hE0;
            4'd3:    bits = 8'hF0;
            4'd4:    bits = 8'hF8;
            4'd5:    bits = 8'hFC;
            4'd6:    bits = 8'hFE;
            4'd7:    bits = 8'hFF;
            4'd8:    bits = 8'hFC;
            4'd9:    bits = 8'hFC;
            4'd10:   bits = 8'hF0;
            4'd11:   bits = 8'hD8;
            4'd12:   bits = 8'h98;
            4'd13:   bits = 8'h0C;
            4'd14:   bits = 8'h0C;
            4'd15:   bits = 8'h06;
            default: bits = '0;
        endcase
        return bits;
    endfunction

    // Outline bits of a row: a set bit is interior only when the bit to its
    // left and the bit above are both set; column 0 and row 0 have no such
    // neighbor, so they are always outline.
    function automatic logic [SPRITE_COLS-1:0] arrow_edge(input logic [ROW_BITS-1:0] row);
        logic [SPRITE_COLS-1:0] cur;
        logic [SPRITE_COLS-1:0] above;
        logic [SPRITE_COLS-1:0] left;
        cur   = arrow_row(row);
        above = (row == '0) ? '0 : arrow_row(row - 1'b1);
        left  = cur >> 1;
        return cur & ~(left & above);
    endfunction

endpackage

FILE: src/cso_intf.sv
`timescale 1ns / 1ps
// Channel interfaces of the cursor overlay: pixel beats in, overlay beats out.
// Depends on cso_pkg.

interface cso_pixel_if
    import cso_pkg::*;
#(
    parameter int COORD_BITS = CSO_COORD_BITS
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_W-1:0]    background_pixel;

    modport source (output valid, output pixel_x, output pixel_y,
                    output background_pixel, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y,
                    input background_pixel, output ready);
endinterface

interface cso_overlay_if
    import cso_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_color;
    logic               cursor_hit;

    modport source (output valid, output pixel_color, output cursor_hit, input ready);
    modport sink   (input valid, input pixel_color, input cursor_hit, output ready);
endinterface

FILE: src/cso_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register bank of the cursor overlay.
// Depends on cso_pkg.

module cso_cfg_regs
    import cso_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cso_cfg_t              cfg
);

    cso_cfg_t cfg_reg;
    cso_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CURSOR_X:      cfg_next.cursor_x      = signed'(cfg_data[CFG_W-1:0]);
                REG_CURSOR_Y:      cfg_next.cursor_y      = signed'(cfg_data[CFG_W-1:0]);
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_data[CFG_W-1:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_data[CFG_W-1:0];
                REG_BORDER_COLOR:  cfg_next.border_color  = cfg_data[COLOR_W-1:0];
                REG_FILL_COLOR:    cfg_next.fill_color    = cfg_data[COLOR_W-1:0];
                default:           cfg_next = cfg_reg;   // drop writes past the list
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cursor_x      <= signed'(RST_CURSOR_X);
            cfg_reg.cursor_y      <= signed'(RST_CURSOR_Y);
            cfg_reg.screen_width  <= RST_SCREEN_WIDTH;
            cfg_reg.screen_height <= RST_SCREEN_HEIGHT;
            cfg_reg.border_color  <= RST_BORDER_COLOR;
            cfg_reg.fill_color    <= RST_FILL_COLOR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/cso_sprite_eval.sv
`timescale 1ns / 1ps
// Per-pixel cursor decision: clip, sprite offset, bitmap lookup, border/fill select.
// Depends on cso_pkg.

module cso_sprite_eval
    import cso_pkg::*;
#(
    parameter int COORD_BITS = CSO_COORD_BITS
) (
    input  logic [COORD_BITS-1:0] pixel_x,
    input  logic [COORD_BITS-1:0] pixel_y,
    input  logic [COLOR_W-1:0]    background_pixel,
    input  cso_cfg_t              cfg,
    output logic [COLOR_W-1:0]    pixel_color,
    output logic                  cursor_hit
);

    localparam int MW = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;
    localparam int DW = MW + 2;   // signed offset, holds max coord plus 4096

    logic [MW-1:0]        px_w;
    logic [MW-1:0]        py_w;
    logic [MW-1:0]        sw_w;
    logic [MW-1:0]        sh_w;
    logic                 visible;
    logic signed [DW-1:0] col;
    logic signed [DW-1:0] row;
    logic                 in_sprite;
    logic [SPRITE_COLS-1:0] row_bits;
    logic [SPRITE_COLS-1:0] edge_bits;
    logic [COL_BITS-1:0]  bit_pos;

    assign px_w = {{(MW-COORD_BITS){1'b0}}, pixel_x};
    assign py_w = {{(MW-COORD_BITS){1'b0}}, pixel_y};
    assign sw_w = {{(MW-CFG_W){1'b0}}, cfg.screen_width};
    assign sh_w = {{(MW-CFG_W){1'b0}}, cfg.screen_height};

    assign visible = (px_w < sw_w) && (py_w < sh_w);

    assign col = signed'({{(DW-COORD_BITS){1'b0}}, pixel_x})
               - signed'({{(DW-CFG_W){cfg.cursor_x[CFG_W-1]}}, cfg.cursor_x});
    assign row = signed'({{(DW-COORD_BITS){1'b0}}, pixel_y})
               - signed'({{(DW-CFG_W){cfg.cursor_y[CFG_W-1]}}, cfg.cursor_y});

    // In the sprite when 0 <= col < 8 and 0 <= row < 16
    assign in_sprite = (col[DW-1:COL_BITS] == '0) && (row[DW-1:ROW_BITS] == '0);

    assign row_bits  = arrow_row(row[ROW_BITS-1:0]);
    assign edge_bits = arrow_edge(row[ROW_BITS-1:0]);
    assign bit_pos   = COL_BITS'(SPRITE_COLS - 1) - col[COL_BITS-1:0];

    always_comb
    begin
        pixel_color = background_pixel;
        cursor_hit  = 1'b0;
        if (visible && in_sprite && row_bits[bit_pos])
        begin
            cursor_hit  = 1'b1;
            pixel_color = edge_bits[bit_pos] ? cfg.border_color : cfg.fill_color;
        end
    end

endmodule

FILE: src/cursor_sprite_overlay.sv
`timescale 1ns / 1ps
// Top level of the hardware cursor overlay: input register, sprite decision, result register.
// Depends on cso_pkg, cso_intf, cso_cfg_regs and cso_sprite_eval.
//
//   Channel   Direction  Handshake        Beat contents
//   pixel     in         valid/ready      pixel_x, pixel_y, background_pixel
//   overlay   out        valid/ready      pixel_color, cursor_hit
//   cfg_*     in         write enable     cfg_index, cfg_data (no read-back)
//
// One pixel beat per clock, sustained while overlay is ready. A beat is captured in the input
// register, passes through the sprite decision and is then captured in the result register.
// The sprite decision between the two registers sets the clock period: one
// 15-bit subtract per axis, a 13-bit clip compare per axis and a 16-entry bitmap lookup.
// Reset (rst_n low, asynchronous) empties both registers and loads the register
// reset values. A stall on overlay holds the result; pixel keeps accepting while
// the input register is free or can move forward in the same cycle.

module cursor_sprite_overlay
    import cso_pkg::*;
#(
    parameter int COORD_BITS = CSO_COORD_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    cso_pixel_if.sink             pixel,
    cso_overlay_if.source         overlay
);

    cso_cfg_t cfg;

    // Input register
    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [COORD_BITS-1:0] in_x_reg;
    logic [COORD_BITS-1:0] in_y_reg;
    logic [COLOR_W-1:0]    in_bg_reg;

    // Result register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [COLOR_W-1:0]    out_color_reg;
    logic                  out_hit_reg;

    logic [COLOR_W-1:0]    eval_color;
    logic                  eval_hit;
    logic                  in_accept;
    logic                  advance;

    cso_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cso_sprite_eval #(
        .COORD_BITS (COORD_BITS)
    ) u_sprite_eval (
        .pixel_x          (in_x_reg),
        .pixel_y          (in_y_reg),
        .background_pixel (in_bg_reg),
        .cfg              (cfg),
        .pixel_color      (eval_color),
        .cursor_hit       (eval_hit)
    );

    // Advance the input register whenever the result register is empty or drains
    assign advance      = in_valid_reg && (!out_valid_reg || overlay.ready);
    assign pixel.ready  = !in_valid_reg || advance;
    assign in_accept    = pixel.valid && pixel.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (pixel.ready)
        begin
            in_valid_next = pixel.valid;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (overlay.ready)
        begin
            out_valid_next = 1'b0;   // drop the beat once taken
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: no reset, loaded only on a moving beat
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_x_reg  <= pixel.pixel_x;
            in_y_reg  <= pixel.pixel_y;
            in_bg_reg <= pixel.background_pixel;
        end
        if (advance)
        begin
            out_color_reg <= eval_color;
            out_hit_reg   <= eval_hit;
        end
    end

    assign overlay.valid       = out_valid_reg;
    assign overlay.pixel_color = out_color_reg;
    assign overlay.cursor_hit  = out_hit_reg;

    // An accepted beat is always held in the input register next cycle
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_valid_reg)
        else $error("accepted pixel beat lost");

    // A beat that leaves the input register always shows up as a result
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced beat did not reach the result register");

    // While the output stalls, the waiting input beat holds its place and value
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !overlay.ready)
            |=> (in_valid_reg && $stable(in_x_reg) && $stable(in_y_reg)
                 && $stable(in_bg_reg)))
        else $error("input register changed during output stall");

    // A pending result holds in the result register until the sink takes it
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !overlay.ready && !advance) |=> out_valid_reg)
        else $error("pending result dropped");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for cursor_sprite_overlay: pixel beats are checked against a behavioral
// overlay predictor, with directed corners and random settings. Depends on cso_pkg, cso_intf and the RTL.

module tb_top;
    import cso_pkg::*;

    localparam int PIX_W         = CSO_COORD_BITS;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 6;       // two-deep pipeline, plus margin
    localparam int RAND_PHASES   = 12;
    localparam int RAND_BEATS    = 95;      // per random phase
    localparam int CYCLE_LIMIT   = 200000;

    // Indexes past the last register; the block must ignore writes to them
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    // Arrow glyph, row 0 in the top byte, MSB of each byte is column 0
    localparam logic [SPRITE_ROWS*SPRITE_COLS-1:0] ARROW_GLYPH =
        128'h80C0E0F0_F8FCFEFF_FCFCF0D8_980C0C06;

    typedef struct packed {
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic [COLOR_W-1:0] bg;
    } pixel_beat_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               hit;
    } overlay_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cso_pixel_if #(.COORD_BITS(PIX_W)) pix_if ();
    cso_overlay_if                     ovl_if ();

    cursor_sprite_overlay #(.COORD_BITS(PIX_W)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pix_if),
        .overlay   (ovl_if)
    );

    // Shadow copy of the register file, updated as each write goes out
    logic [CFG_W-1:0]   shadow_cursor_x;
    logic [CFG_W-1:0]   shadow_cursor_y;
    logic [CFG_W-1:0]   shadow_width;
    logic [CFG_W-1:0]   shadow_height;
    logic [COLOR_W-1:0] shadow_border;
    logic [COLOR_W-1:0] shadow_fill;

    pixel_beat_t   pending_pixels[$];      // beats not yet offered to the block
    overlay_beat_t expected_overlay[$];    // predicted results, oldest first
    pixel_beat_t   next_beat;
    pixel_beat_t   taken_beat;
    overlay_beat_t predicted;
    overlay_beat_t want;

    bit idle_on = 1'b1;                    // enables random gaps and stalls
    bit pix_taken = 1'b0;                  // a pixel beat moved at the last rising edge
    int pix_gap = 0;
    int ovl_gap = 0;
    int queued_cnt = 0;
    int accepted_cnt = 0;
    int checked_cnt = 0;
    int cursor_hits = 0;
    int reg_writes = 0;
    int mismatches = 0;
    int cycle_cnt = 0;

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Glyph lookup; anything outside the 16x8 box reads as clear
    function automatic logic arrow_bit(int row, int col);
        if (row < 0 || row >= SPRITE_ROWS || col < 0 || col >= SPRITE_COLS)
            return 1'b0;
        return ARROW_GLYPH[SPRITE_ROWS*SPRITE_COLS - 1 - row*SPRITE_COLS - col];
    endfunction

    // Color after overlay for one pixel under the shadow settings. Clipping
    // only gates the hit; the outline test always looks at the full glyph.
    function automatic overlay_beat_t cursor_overlay(pixel_beat_t beat);
        overlay_beat_t res;
        int            col;
        int            row;
        logic          outline;
        res.color = beat.bg;
        res.hit   = 1'b0;
        if (beat.x < shadow_width && beat.y < shadow_height) begin
            col = int'(beat.x) - int'($signed(shadow_cursor_x));
            row = int'(beat.y) - int'($signed(shadow_cursor_y));
            if (arrow_bit(row, col)) begin
                outline = (col == 0) || (row == 0) ||
                          !arrow_bit(row, col - 1) || !arrow_bit(row - 1, col);
                res.color = outline ? shadow_border : shadow_fill;
                res.hit   = 1'b1;
            end
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Pixel driver: change at the falling edge, hold until the beat moves
    // ---------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n) begin
            if (!pix_if.valid || pix_taken) begin
                if (pix_gap != 0) begin
                    // finish the current idle burst
                    pix_gap      <= pix_gap - 1;
                    pix_if.valid <= 1'b0;
                end else if (pending_pixels.size() != 0 && idle_on &&
                             $urandom_range(0, 7) == 0) begin
                    // open an idle burst, its length drawn at random into pix_gap
                    pix_gap      <= $urandom_range(0, 5);
                    pix_if.valid <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    next_beat               = pending_pixels.pop_front();
                    pix_if.valid            <= 1'b1;
                    pix_if.pixel_x          <= next_beat.x;
                    pix_if.pixel_y          <= next_beat.y;
                    pix_if.background_pixel <= next_beat.bg;
                end else begin
                    pix_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Overlay sink: drop ready for random bursts of clock cycles
    // ---------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n) begin
            if (ovl_gap != 0) begin
                ovl_gap      <= ovl_gap - 1;
                ovl_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                ovl_gap      <= $urandom_range(0, 5);
                ovl_if.ready <= 1'b0;
            end else begin
                ovl_if.ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: predict on each accepted pixel beat, check each overlay beat
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        pix_taken <= rst_n && pix_if.valid && pix_if.ready;

        if (rst_n && pix_if.valid && pix_if.ready) begin
            taken_beat.x  = pix_if.pixel_x;
            taken_beat.y  = pix_if.pixel_y;
            taken_beat.bg = pix_if.background_pixel;
            predicted     = cursor_overlay(taken_beat);
            expected_overlay.push_back(predicted);
            accepted_cnt++;
            if (predicted.hit)
                cursor_hits++;
        end

        if (rst_n && ovl_if.valid && ovl_if.ready) begin
            if (expected_overlay.size() == 0) begin
                $error("overlay beat with no pixel pending: pixel_color %h cursor_hit %b",
                       ovl_if.pixel_color, ovl_if.cursor_hit);
                mismatches++;
            end else begin
                want = expected_overlay.pop_front();
                if (ovl_if.pixel_color !== want.color) begin
                    $error("pixel_color: expected %h, actual %h",
                           want.color, ovl_if.pixel_color);
                    mismatches++;
                end
                if (ovl_if.cursor_hit !== want.hit) begin
                    $error("cursor_hit: expected %b, actual %b",
                           want.hit, ovl_if.cursor_hit);
                    mismatches++;
                end
                checked_cnt++;
            end
        end
    end

    // Watchdog: stop a hung run
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $error("cycle limit reached with %0d results outstanding",
                   expected_overlay.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // One-cycle register write; mirror it into the shadow copy
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        reg_writes++;
        case (idx)
            REG_CURSOR_X:      shadow_cursor_x = data[CFG_W-1:0];
            REG_CURSOR_Y:      shadow_cursor_y = data[CFG_W-1:0];
            REG_SCREEN_WIDTH:  shadow_width    = data[CFG_W-1:0];
            REG_SCREEN_HEIGHT: shadow_height   = data[CFG_W-1:0];
            REG_BORDER_COLOR:  shadow_border   = data;
            REG_FILL_COLOR:    shadow_fill     = data;
            default: ;
        endcase
    endtask

    task automatic queue_pixel(input int x, input int y, input logic [COLOR_W-1:0] bg);
        pixel_beat_t beat;
        beat.x  = PIX_W'(x);
        beat.y  = PIX_W'(y);
        beat.bg = bg;
        pending_pixels.push_back(beat);
        queued_cnt++;
    endtask

    // Block until every queued beat went in and every result came back,
    // then let the pipeline settle so the next write lands on an idle block
    task automatic wait_drained();
        while (accepted_cnt != queued_cnt || expected_overlay.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Put random junk above bit 12 so the width masking gets exercised
    function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_W-1:0] value);
        logic [CFG_DATA_W-1:0] data;
        data = $urandom;
        data[CFG_W-1:0] = value;
        return data;
    endfunction

    function automatic logic [CFG_W-1:0] pick_extent();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_W'(1);
            2:       return CFG_W'(4096);
            3:       return '1;
            4:       return CFG_W'($urandom_range(1, 16));
            default: return CFG_W'($urandom_range(1, 4096));
        endcase
    endfunction

    // Cursor position: range ends, partly off the low side, straddling the
    // clip edge, near the top of the coordinate range, or plain on screen
    function automatic logic [CFG_W-1:0] pick_position(logic [CFG_W-1:0] extent);
        case ($urandom_range(0, 7))
            0:       return CFG_W'(-4096);
            1:       return CFG_W'(4095);
            2:       return CFG_W'(-int'($urandom_range(1, 15)));
            3:       return CFG_W'(int'(extent) - int'($urandom_range(0, 8)));
            4:       return CFG_W'($urandom_range(4080, 4095));
            default: return CFG_W'($urandom_range(0, 1100));
        endcase
    endfunction

    task automatic randomize_settings();
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        w = pick_extent();
        h = pick_extent();
        write_reg(REG_SCREEN_WIDTH,  with_junk(w));
        write_reg(REG_SCREEN_HEIGHT, with_junk(h));
        write_reg(REG_CURSOR_X,      with_junk(pick_position(w)));
        write_reg(REG_CURSOR_Y,      with_junk(pick_position(h)));
        write_reg(REG_BORDER_COLOR,  $urandom);
        write_reg(REG_FILL_COLOR,    $urandom);
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? IDX_SPARE_LO : IDX_SPARE_HI, $urandom);
    endtask

    // Mostly pixels in and just around the sprite box, the rest anywhere
    task automatic queue_random_pixels(input int count);
        int sx;
        int sy;
        sx = $signed(shadow_cursor_x);
        sy = $signed(shadow_cursor_y);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 7)
                queue_pixel(sx + int'($urandom_range(0, SPRITE_COLS + 1)) - 1,
                            sy + int'($urandom_range(0, SPRITE_ROWS + 1)) - 1,
                            $urandom);
            else
                queue_pixel($urandom_range(0, (1 << PIX_W) - 1),
                            $urandom_range(0, (1 << PIX_W) - 1),
                            $urandom);
        end
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        // known levels on every input from time zero
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = '0;
        cfg_data                = '0;
        pix_if.valid            = 1'b0;
        pix_if.pixel_x          = '0;
        pix_if.pixel_y          = '0;
        pix_if.background_pixel = '0;
        ovl_if.ready            = 1'b0;

        shadow_cursor_x = RST_CURSOR_X;
        shadow_cursor_y = RST_CURSOR_Y;
        shadow_width    = RST_SCREEN_WIDTH;
        shadow_height   = RST_SCREEN_HEIGHT;
        shadow_border   = RST_BORDER_COLOR;
        shadow_fill     = RST_FILL_COLOR;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: outline tip, an interior pixel, clip edges, far corner, a pixel below the sprite
        queue_pixel(0, 0, 32'h0000_0000);
        queue_pixel(3, 7, 32'hFFFF_FFFF);
        queue_pixel(1023, 767, 32'hAAAA_5555);
        queue_pixel(1024, 767, 32'h5555_AAAA);
        queue_pixel(4095, 4095, 32'hFFFF_FFFF);
        queue_pixel(0, 16, 32'h0000_0000);
        wait_drained();

        // Sprite hanging off the top-left corner: clipped pixels stay interior
        write_reg(REG_CURSOR_X,      32'h0000_1FFD);
        write_reg(REG_CURSOR_Y,      32'h0000_1FFB);
        write_reg(REG_SCREEN_WIDTH,  32'h0000_1000);
        write_reg(REG_SCREEN_HEIGHT, 32'h0000_1FFF);
        write_reg(REG_BORDER_COLOR,  32'hFFFF_FFFF);
        write_reg(REG_FILL_COLOR,    32'h0000_0000);
        queue_pixel(0, 0, $urandom);
        queue_pixel(1, 2, $urandom);
        queue_pixel(0, 3, $urandom);
        queue_pixel(4, 2, $urandom);
        queue_pixel(2, 4, $urandom);
        wait_drained();

        // Zero width clips everything, even a pixel right on the glyph
        write_reg(REG_SCREEN_WIDTH, 32'hFFFF_E000);
        queue_pixel(0, 0, $urandom);
        queue_pixel(2, 2, $urandom);
        wait_drained();

        // Zero height, same story
        write_reg(REG_SCREEN_WIDTH,  32'h0000_0001);
        write_reg(REG_SCREEN_HEIGHT, 32'h0000_0000);
        queue_pixel(0, 0, $urandom);
        wait_drained();

        // Cursor at the top of the range with junk upper bits; oversized
        // screen; spare indexes must not disturb anything
        write_reg(REG_CURSOR_X,      32'hFFFF_EFFF);
        write_reg(REG_CURSOR_Y,      32'hABCD_EFF8);
        write_reg(REG_SCREEN_WIDTH,  32'hFFFF_FFFF);
        write_reg(REG_SCREEN_HEIGHT, 32'h0000_1000);
        write_reg(REG_BORDER_COLOR,  32'h0F0F_F0F0);
        write_reg(REG_FILL_COLOR,    32'h5555_AAAA);
        write_reg(IDX_SPARE_LO,      32'h0000_0000);
        write_reg(IDX_SPARE_HI,      32'hFFFF_FFFF);
        queue_pixel(4095, 4095, $urandom);
        queue_pixel(4095, 4088, $urandom);
        queue_pixel(4094, 4095, $urandom);
        wait_drained();

        // Most negative position: the sprite never reaches the screen
        write_reg(REG_CURSOR_X, 32'h0000_1000);
        write_reg(REG_CURSOR_Y, 32'h0000_1000);
        queue_pixel(0, 0, $urandom);
        queue_pixel(4095, 4095, $urandom);
        wait_drained();

        // Random settings, each with a burst of pixels around the cursor;
        // the closing phases run back to back with no gaps or stalls
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            idle_on = (ph >= RAND_PHASES - 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
            randomize_settings();
            queue_random_pixels(RAND_BEATS);
            wait_drained();
        end

        $display("Covered %0d pixel beats, %0d of them under the cursor, over %0d register writes.",
                 checked_cnt, cursor_hits, reg_writes);
        $display("Settings spanned empty, one-pixel and oversized screens and both position extremes.");
        if (mismatches == 0 && expected_overlay.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
src/cso_pkg.sv
src/cso_intf.sv
src/cso_cfg_regs.sv
src/cso_sprite_eval.sv
src/cursor_sprite_overlay.sv
bench/tb_top.sv
